/* sv/risc_execute_unit_assert.svh */
// assertion macros for the risc execute unit
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef RISC_EXECUTE_UNIT_ASSERT_SVH
`define RISC_EXECUTE_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define RXU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the trigger
`define RXU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rxu_pkg.sv */
// shared types, opcodes and constants of the risc execute unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rxu_pkg;

    localparam int WORD_W   = 32;
    localparam int NUM_REGS = 32;
    localparam int REG_AW   = $clog2(NUM_REGS);
    localparam int FUNC_W   = 6;
    localparam int FLAG_W   = 3;
    localparam int SWI_W    = 8;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [REG_AW-1:0] t_reg_idx;
    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [FLAG_W-1:0] t_flags;
    typedef logic [SWI_W-1:0]  t_swi_num;

    localparam t_reg_idx LINK_REG = t_reg_idx'(30);

    // opcodes
    localparam t_func FN_AND    = t_func'(0);
    localparam t_func FN_OR     = t_func'(1);
    localparam t_func FN_NOT    = t_func'(2);
    localparam t_func FN_XOR    = t_func'(3);
    localparam t_func FN_ADD    = t_func'(4);
    localparam t_func FN_SUB    = t_func'(5);
    localparam t_func FN_LOAD_A = t_func'(11);
    localparam t_func FN_LOAD_B = t_func'(12);
    localparam t_func FN_LEA    = t_func'(13);
    localparam t_func FN_JUMP   = t_func'(16);
    localparam t_func FN_BRANCH = t_func'(17);
    localparam t_func FN_CALL   = t_func'(18);
    localparam t_func FN_CALLR  = t_func'(19);
    localparam t_func FN_JUMPR  = t_func'(20);
    localparam t_func FN_SWI    = t_func'(21);

    // one-hot condition codes
    localparam t_flags FLAG_POS  = 3'b001;
    localparam t_flags FLAG_ZERO = 3'b010;
    localparam t_flags FLAG_NEG  = 3'b100;

    localparam t_word AND_IMM_SET = 32'hFFFF_0000;
    localparam t_word LOG_IMM_MSK = 32'h0000_FFFF;
    localparam t_swi_num SWI_BASE = 8'd128;

endpackage

`default_nettype wire

/* sv/rxu_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rxu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/risc_execute_unit.sv */
// Executes one decoded instruction per cycle while the output is not stalled:
// an instruction can be taken whenever the execute stage is empty or commits,
// and its result reaches the output register when it commits (operands are
// read from the register file ram at the transfer edge, and the instruction
// then executes into the output register).
// The register file is held in two copies of a ram with registered read, one
// per source operand; the instruction committing at the same edge as a new
// transfer is forwarded to it. Registers read as zero until first written
// (a valid bit per register, so no clearing pass after reset). A stalled
// output holds the execute stage, which then stalls the input.
// depends on rxu_pkg, rxu_ram and risc_execute_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "risc_execute_unit_assert.svh"

module risc_execute_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // instruction channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rxu_pkg::t_func     i_func,
    input  wire rxu_pkg::t_reg_idx  i_dest_index,
    input  wire rxu_pkg::t_reg_idx  i_src1_index,
    input  wire rxu_pkg::t_reg_idx  i_src2_index,
    input  wire logic               i_immediate_mode,
    input  wire rxu_pkg::t_word     i_immediate_value,
    input  wire rxu_pkg::t_word     i_offset_value,
    input  wire rxu_pkg::t_flags    i_cond_mask,
    input  wire rxu_pkg::t_word     i_mem_data,
    input  wire rxu_pkg::t_word     i_pc_next,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rxu_pkg::t_word          o_next_pc,
    output logic                    o_write_enable,
    output rxu_pkg::t_reg_idx       o_write_index,
    output rxu_pkg::t_word          o_write_value,
    output rxu_pkg::t_flags         o_flags_out,
    output logic                    o_swi_request,
    output rxu_pkg::t_swi_num       o_swi_number
);

    import rxu_pkg::*;

    // execute stage
    logic      r_exe_vld;
    t_func     r_func;
    t_reg_idx  r_dest;
    t_reg_idx  r_src1;
    logic      r_imm_mode;
    t_word     r_imm;
    t_word     r_off;
    t_flags    r_cmask;
    t_word     r_mdata;
    t_word     r_pc;
    logic      r_fwd1, r_fwd2;
    t_word     r_fwd1_val, r_fwd2_val;
    logic      r_zero1, r_zero2;

    // architectural state besides the ram contents
    logic [NUM_REGS-1:0] r_valid;
    t_flags              r_flags;

    // output register
    logic      r_out_vld;

    logic      w_accept;
    logic      w_commit;
    t_word     w_rd1, w_rd2;
    t_word     w_op1, w_op2;
    t_word     w_alu_b;
    t_word     w_res;
    logic      w_alu;
    t_word     w_tgt_base;
    t_word     w_target;
    t_word     n_npc;
    logic      n_we;
    t_reg_idx  n_widx;
    t_word     n_wval;
    t_flags    n_flags;
    logic      n_swi;
    t_swi_num  n_swin;
    logic      n_fwd1, n_fwd2;

    assign w_commit   = r_exe_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_exe_vld && !w_commit;
    assign w_accept   = i_in_valid && !o_in_stall;

    rxu_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_rf_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_commit && n_we),
        .i_wr_addr (n_widx),
        .i_wr_data (n_wval),
        .i_rd_en   (w_accept),
        .i_rd_addr (i_src1_index),
        .o_rd_data (w_rd1)
    );

    rxu_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_rf_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_commit && n_we),
        .i_wr_addr (n_widx),
        .i_wr_data (n_wval),
        .i_rd_en   (w_accept),
        .i_rd_addr (i_src2_index),
        .o_rd_data (w_rd2)
    );

    // forward the write that lands on the same edge as the read
    assign n_fwd1 = w_commit && n_we && (n_widx == i_src1_index);
    assign n_fwd2 = w_commit && n_we && (n_widx == i_src2_index);

    always_comb begin
        w_op1 = r_fwd1 ? r_fwd1_val : (r_zero1 ? '0 : w_rd1);
        w_op2 = r_fwd2 ? r_fwd2_val : (r_zero2 ? '0 : w_rd2);

        case (r_func)
            FN_AND:          w_alu_b = r_imm_mode ? (r_imm | AND_IMM_SET) : w_op2;
            FN_OR, FN_XOR:   w_alu_b = r_imm_mode ? (r_imm & LOG_IMM_MSK) : w_op2;
            default:         w_alu_b = r_imm_mode ? r_imm : w_op2;
        endcase

        w_alu = 1'b1;
        case (r_func)
            FN_AND:  w_res = w_op1 & w_alu_b;
            FN_OR:   w_res = w_op1 | w_alu_b;
            FN_NOT:  w_res = ~w_op1;
            FN_XOR:  w_res = w_op1 ^ w_alu_b;
            FN_ADD:  w_res = w_op1 + w_alu_b;
            FN_SUB:  w_res = w_op1 - w_alu_b;
            default: begin
                w_res = '0;
                w_alu = 1'b0;
            end
        endcase

        // one adder for every control transfer target and lea
        // callr through the link register sees the return address
        if ((r_func == FN_JUMPR) || ((r_func == FN_CALLR) && (r_src1 != LINK_REG))) begin
            w_tgt_base = w_op1;
        end else begin
            w_tgt_base = r_pc;
        end
        w_target = w_tgt_base + r_off;

        n_npc   = r_pc;
        n_we    = 1'b0;
        n_widx  = '0;
        n_wval  = '0;
        n_flags = r_flags;
        n_swi   = 1'b0;
        n_swin  = '0;

        if (w_alu) begin
            n_we   = 1'b1;
            n_widx = r_dest;
            n_wval = w_res;
            if (w_res == '0) begin
                n_flags = FLAG_ZERO;
            end else if (w_res[WORD_W-1]) begin
                n_flags = FLAG_NEG;
            end else begin
                n_flags = FLAG_POS;
            end
        end else begin
            case (r_func)
                FN_LOAD_A, FN_LOAD_B: begin
                    n_we   = 1'b1;
                    n_widx = r_dest;
                    n_wval = r_mdata;
                end
                FN_LEA: begin
                    n_we   = 1'b1;
                    n_widx = r_dest;
                    n_wval = w_target;
                end
                FN_JUMP, FN_JUMPR: begin
                    n_npc = w_target;
                end
                FN_BRANCH: begin
                    if ((r_flags & r_cmask) != '0) begin
                        n_npc = w_target;
                    end
                end
                FN_CALL, FN_CALLR: begin
                    n_we   = 1'b1;
                    n_widx = LINK_REG;
                    n_wval = r_pc;
                    n_npc  = w_target;
                end
                FN_SWI: begin
                    n_swi  = 1'b1;
                    n_swin = SWI_BASE + {1'b0, w_op1[SWI_W-2:0]};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exe_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_valid   <= '0;
            r_flags   <= '0;
        end else begin
            if (w_accept) begin
                r_exe_vld <= 1'b1;
            end else if (w_commit) begin
                r_exe_vld <= 1'b0;
            end
            if (w_commit) begin
                r_out_vld <= 1'b1;
                r_flags   <= n_flags;
                if (n_we) begin
                    r_valid[n_widx] <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload of the execute stage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func     <= i_func;
            r_dest     <= i_dest_index;
            r_src1     <= i_src1_index;
            r_imm_mode <= i_immediate_mode;
            r_imm      <= i_immediate_value;
            r_off      <= i_offset_value;
            r_cmask    <= i_cond_mask;
            r_mdata    <= i_mem_data;
            r_pc       <= i_pc_next;
            r_fwd1     <= n_fwd1;
            r_fwd2     <= n_fwd2;
            r_fwd1_val <= n_wval;
            r_fwd2_val <= n_wval;
            r_zero1    <= !r_valid[i_src1_index];
            r_zero2    <= !r_valid[i_src2_index];
        end
    end

    // payload of the output register
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            o_next_pc      <= n_npc;
            o_write_enable <= n_we;
            o_write_index  <= n_widx;
            o_write_value  <= n_wval;
            o_flags_out    <= n_flags;
            o_swi_request  <= n_swi;
            o_swi_number   <= n_swin;
        end
    end

    assign o_out_valid = r_out_vld;

    `RXU_ASSERT_SAME(a_flags_onehot, 1'b1, $onehot0(r_flags),
        "condition register not one-hot")
    `RXU_ASSERT_NEXT(a_commit_shows, w_commit, r_out_vld,
        "executed instruction did not reach the output")
    `RXU_ASSERT_SAME(a_swi_no_write, r_out_vld && o_swi_request, !o_write_enable,
        "software interrupt also writes a register")
    `RXU_ASSERT_SAME(a_idle_write_clear, r_out_vld && !o_write_enable,
        (o_write_index == '0) && (o_write_value == '0),
        "write fields not cleared without a register write")

endmodule

`default_nettype wire
